@@ hdl/fusp_pkg.sv @@
// ----------------------------------------------------------------------------
// fusp_pkg
// Shared constants, types and helpers of the form-urlencoded stream parser.
// ----------------------------------------------------------------------------
package fusp_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  // escape phase codes
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // results one input item can cause
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  typedef struct packed {
    logic [7:0] data;
    logic       vside;
    logic       pend;
  } res_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

@@ hdl/form_urlencoded_stream_parser_core.sv @@
// ----------------------------------------------------------------------------
// form_urlencoded_stream_parser_core
// Streaming percent-decoder for a form body, split into name/value items.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw body byte per item in in_tdata; in_tlast marks the final
//           byte of the body and closes the last pair.
//   out_* : decoded bytes in out_tdata, tagged name/value in out_tuser[0];
//           out_tuser[1] flags an end-of-pair marker (data zero). out_tlast
//           marks the last result caused by one input item.
// An input item is registered, decoded combinationally into a four-entry result
// buffer, and drained one result per cycle while out_tready is high. The first
// result leaves from the result buffer, behind the input register. An item
// yielding one result sustains one item per cycle while out_tready stays high;
// an item yielding k results (k is 0..4; broken escapes and end-of-pair markers
// give the bursts) drains one by one through the buffer's single output port.
// Reset (rst_n low, synchronous) empties both stages and returns the parser
// to the start of a name with no escape pending.
// When out_tready is low the buffer holds; the input register still takes
// one more item, then in_tready drops until the buffer frees.
// ----------------------------------------------------------------------------
module form_urlencoded_stream_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] in_value_part, [1] pair_end
  output logic       out_tlast   // last_of_run
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parser state
  logic [1:0] esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;
  logic       vside_r, vside_nxt;
  logic       started_r, started_nxt;

  // result buffer
  fusp_pkg::res_t                  res_r [fusp_pkg::MAX_RES];
  fusp_pkg::res_t                  dec_res [fusp_pkg::MAX_RES];
  logic [fusp_pkg::CNT_W-1:0]      rem_r, rem_nxt;
  logic [fusp_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [fusp_pkg::CNT_W-1:0]      dec_n;

  logic in_fire, out_fire, buf_free, s1_adv;

  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = (rem_r == '0) ||
                     (rem_r == fusp_pkg::CNT_W'(1) && out_tready);
  assign s1_adv    = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || buf_free;
  assign in_fire   = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Decode of one byte against the current state
  // --------------------------------------------------------------------------
  always_comb begin
    logic [1:0]                 ph;
    logic [7:0]                 hd;
    logic                       vs;
    logic                       ps;
    logic [fusp_pkg::CNT_W-1:0] n;
    logic                       close_req;
    logic                       hexb;
    logic [7:0]                 b;

    b         = s1_byte_r;
    hexb      = fusp_pkg::is_hex(b);
    ph        = esc_r;
    hd        = held_r;
    vs        = vside_r;
    ps        = started_r;
    n         = '0;
    close_req = 1'b0;
    for (int i = 0; i < fusp_pkg::MAX_RES; i++) begin
      dec_res[i] = '0;
    end

    if (b == fusp_pkg::CH_AMP) begin
      close_req = 1'b1;
    end else begin
      ps = 1'b1;
      if (ph == fusp_pkg::ESC_PCT && hexb) begin
        hd = b;
        ph = fusp_pkg::ESC_DIGIT;
      end else if (ph == fusp_pkg::ESC_DIGIT && hexb) begin
        dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: {fusp_pkg::hex_val(hd),
                                                   fusp_pkg::hex_val(b)},
                                            vside: vs, pend: 1'b0};
        n  = n + 1'b1;
        ph = fusp_pkg::ESC_NONE;
      end else begin
        // broken escape: pending bytes go out literally
        if (ph == fusp_pkg::ESC_PCT || ph == fusp_pkg::ESC_DIGIT) begin
          dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: fusp_pkg::CH_PCT, vside: vs,
                                              pend: 1'b0};
          n = n + 1'b1;
        end
        if (ph == fusp_pkg::ESC_DIGIT) begin
          dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: hd, vside: vs, pend: 1'b0};
          n = n + 1'b1;
        end
        ph = fusp_pkg::ESC_NONE;
        if (b == fusp_pkg::CH_EQ && !vs) begin
          vs = 1'b1;
        end else if (b == fusp_pkg::CH_PLUS) begin
          dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: fusp_pkg::CH_SPACE, vside: vs,
                                              pend: 1'b0};
          n = n + 1'b1;
        end else if (b == fusp_pkg::CH_PCT) begin
          ph = fusp_pkg::ESC_PCT;
        end else begin
          dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: b, vside: vs, pend: 1'b0};
          n = n + 1'b1;
        end
      end
      if (s1_last_r) begin
        close_req = 1'b1;
      end
    end

    if (close_req) begin
      if (ph == fusp_pkg::ESC_PCT || ph == fusp_pkg::ESC_DIGIT) begin
        dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: fusp_pkg::CH_PCT, vside: vs,
                                            pend: 1'b0};
        n = n + 1'b1;
      end
      if (ph == fusp_pkg::ESC_DIGIT) begin
        dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: hd, vside: vs, pend: 1'b0};
        n = n + 1'b1;
      end
      if (ps) begin
        dec_res[n[fusp_pkg::IDX_W-1:0]] = '{data: 8'h00, vside: vs, pend: 1'b1};
        n = n + 1'b1;
      end
      ph = fusp_pkg::ESC_NONE;
      vs = 1'b0;
      ps = 1'b0;
    end

    dec_n       = n;
    esc_nxt     = ph;
    held_nxt    = hd;
    vside_nxt   = vs;
    started_nxt = ps;
  end

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (s1_adv) begin
      rem_nxt = dec_n;
      idx_nxt = '0;
    end else if (out_fire) begin
      rem_nxt = rem_r - 1'b1;
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      esc_r      <= fusp_pkg::ESC_NONE;
      held_r     <= 8'h00;
      vside_r    <= 1'b0;
      started_r  <= 1'b0;
      rem_r      <= '0;
      idx_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      rem_r      <= rem_nxt;
      idx_r      <= idx_nxt;
      if (s1_adv) begin
        esc_r     <= esc_nxt;
        held_r    <= held_nxt;
        vside_r   <= vside_nxt;
        started_r <= started_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv) begin
      for (int i = 0; i < fusp_pkg::MAX_RES; i++) begin
        res_r[i] <= dec_res[i];
      end
    end
  end

  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = res_r[idx_r].data;
  assign out_tuser  = {res_r[idx_r].pend, res_r[idx_r].vside};
  assign out_tlast  = (rem_r == fusp_pkg::CNT_W'(1));

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= fusp_pkg::CNT_W'(fusp_pkg::MAX_RES))
    else $error("result count exceeds buffer depth");

  a_esc_code: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r != 2'd3)
    else $error("unused escape phase reached");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 8'h00)
    else $error("end-of-pair marker carries data");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_tlast |=> out_tvalid)
    else $error("run of results broken before its last item");

  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && dec_n == '0 |=> !out_tvalid)
    else $error("result shown for an item with no results");

  a_marker_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && dec_res[0].pend |=> !started_r && !vside_r && esc_r == fusp_pkg::ESC_NONE)
    else $error("pair state not cleared after marker");

endmodule

@@ tb/form_urlencoded_stream_parser_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urlencoded_stream_parser_core_tb
// Streams form bodies into the parser and checks every decoded item against a
// behavioural decoder: directed corner cases (escapes, broken and cut escapes,
// empty and '='-only pairs, byte extremes), then random pairs
// mixed with noise, under random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module form_urlencoded_stream_parser_core_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_ITEMS  = 142;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       drain;  // hold this item until every decoded item is back
  } body_t;

  typedef struct {
    logic [7:0] data;
    logic       vside;
    logic       pend;
    logic       last;
  } dec_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [1:0] out_tuser;          // [0] in_value_part, [1] pair_end
  logic       out_tlast;          // last_of_run

  form_urlencoded_stream_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  body_t body_q[$];
  dec_t  decoded_q[$];
  int    n_queued = 0;
  int    n_taken = 0;
  int    n_sent = 0;
  int    errors = 0;
  int    cycles = 0;
  int    gap_left = 0;
  int    stall_left = 0;
  logic  took_item = 1'b0;

  // decoder state
  logic [1:0] esc_state = fusp_pkg::ESC_NONE;
  logic [7:0] held_hex = 8'h00;
  logic       on_value = 1'b0;
  logic       pair_open = 1'b0;

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic void emit_dec(input logic [7:0] d, input logic is_end);
    dec_t e;
    e.data  = d;
    e.vside = on_value;
    e.pend  = is_end;
    e.last  = 1'b0;
    decoded_q.insert(decoded_q.size(), e);
  endfunction

  function automatic void flush_escape();
    if (esc_state == fusp_pkg::ESC_PCT || esc_state == fusp_pkg::ESC_DIGIT) begin
      emit_dec(fusp_pkg::CH_PCT, 1'b0);
    end
    if (esc_state == fusp_pkg::ESC_DIGIT) emit_dec(held_hex, 1'b0);
    esc_state = fusp_pkg::ESC_NONE;
  endfunction

  function automatic void close_pair();
    flush_escape();
    if (pair_open) emit_dec(8'h00, 1'b1);
    on_value  = 1'b0;
    pair_open = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    int n0;
    n0 = decoded_q.size();
    if (b == fusp_pkg::CH_AMP) begin
      close_pair();
    end else begin
      pair_open = 1'b1;
      if (esc_state == fusp_pkg::ESC_PCT && hex_digit(b)) begin
        held_hex  = b;
        esc_state = fusp_pkg::ESC_DIGIT;
      end else if (esc_state == fusp_pkg::ESC_DIGIT && hex_digit(b)) begin
        emit_dec({nibble(held_hex), nibble(b)}, 1'b0);
        esc_state = fusp_pkg::ESC_NONE;
      end else begin
        flush_escape();
        if (b == fusp_pkg::CH_EQ && !on_value) begin
          on_value = 1'b1;
        end else if (b == fusp_pkg::CH_PLUS) begin
          emit_dec(fusp_pkg::CH_SPACE, 1'b0);
        end else if (b == fusp_pkg::CH_PCT) begin
          esc_state = fusp_pkg::ESC_PCT;
        end else begin
          emit_dec(b, 1'b0);
        end
      end
      if (lst) close_pair();
    end
    if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // every third stretch of 40 items runs with no idling at all
  function automatic logic calm();
    return ((n_sent / 40) % 3) == 2;
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 16) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 16);
  endfunction

  task automatic push_item(input logic [7:0] b, input logic lst, input logic drn);
    body_t it;
    it.b     = b;
    it.last  = lst;
    it.drain = drn;
    body_q.insert(body_q.size(), it);
    n_queued++;
  endtask

  task automatic push_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) push_item(s[i], close && (i == s.len() - 1), 1'b0);
  endtask

  // one name or value part: plain bytes, '+', good and broken escapes
  task automatic push_part();
    int   toks;
    int   r;
    logic [7:0] c;
    toks = $urandom_range(0, 4);
    for (int t = 0; t < toks; t++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        c = 8'($urandom_range(8'h21, 8'h7e));
        if (c == fusp_pkg::CH_AMP) c = "x";
        push_item(c, 1'b0, 1'b0);
      end else if (r < 70) begin
        push_item(fusp_pkg::CH_PLUS, 1'b0, 1'b0);
      end else if (r < 92) begin
        push_item(fusp_pkg::CH_PCT, 1'b0, 1'b0);
        push_item(rand_hex(), 1'b0, 1'b0);
        push_item(rand_hex(), 1'b0, 1'b0);
      end else begin
        push_item(fusp_pkg::CH_PCT, 1'b0, 1'b0);
        if ($urandom_range(0, 1)) push_item(rand_hex(), 1'b0, 1'b0);
        push_item($urandom_range(0, 1) ? "g" : fusp_pkg::CH_PCT, 1'b0, 1'b0);
      end
    end
  endtask

  // result monitor and input acceptance
  always @(posedge clk) begin
    dec_t e;
    took_item = rst_n && in_tvalid && in_tready;
    if (took_item) begin
      decode_byte(in_tdata, in_tlast);
      n_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item data=%02h user=%b last=%b", $time,
                 out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        e = decoded_q.pop_front();
        if (out_tdata !== e.data || out_tuser[0] !== e.vside || out_tuser[1] !== e.pend ||
            out_tlast !== e.last) begin
          $display("%0t: mismatch exp data=%02h vside=%b pend=%b last=%b", $time,
                   e.data, e.vside, e.pend, e.last);
          $display("%0t:          got data=%02h vside=%b pend=%b last=%b", $time,
                   out_tdata, out_tuser[0], out_tuser[1], out_tlast);
          errors++;
        end
      end
    end
  end

  // body driver
  always @(negedge clk) begin
    body_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !took_item) begin
      // item still waiting for in_tready
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left--;
    end else if (body_q.size() > 0 && !(body_q[0].drain && decoded_q.size() != 0)) begin
      it = body_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= it.b;
      in_tlast  <= it.last;
      n_sent++;
      gap_left = calm() ? 0 : idle_len();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!calm() && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left = idle_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int   r;
    int   mark;
    // directed corner cases
    push_text("a=b", 1'b1);
    push_text("%4f=", 1'b0);        // escape ends the name part
    push_text("=+%zq", 1'b0);       // later '=' literal, broken escape
    push_text("%4g", 1'b0);         // broken after one digit
    push_text("%4&", 1'b0);         // escape cut by '&'
    push_text("=&", 1'b0);          // pair of only '='
    push_text("&", 1'b0);           // empty pair
    push_text("%4z", 1'b1);         // broken escape on the final byte
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_text("a&", 1'b1);          // final byte is '&'
    mark = n_queued;

    // random pairs and noise
    while (n_queued < mark + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        push_part();
        if ($urandom_range(0, 99) < 80) push_item(fusp_pkg::CH_EQ, 1'b0, 1'b0);
        push_part();
        if ($urandom_range(0, 99) < 20 && body_q.size() > 0) begin
          body_q[body_q.size() - 1].last = 1'b1;
        end else begin
          push_item(fusp_pkg::CH_AMP, $urandom_range(0, 9) == 0, 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) push_item(8'($urandom_range(0, 255)),
                                                $urandom_range(0, 9) == 0, 1'b0);
      end
    end
    // pause the sender until the decoder has drained
    body_q[mark].drain = 1'b1;
    body_q[mark + 80].drain = 1'b1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_queued) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
